@@ src/degree_ordered_greedy_graph_coloring_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the degree ordered graph coloring block
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef DEGREE_ORDERED_GREEDY_GRAPH_COLORING_TOP_ASSERT_SVH
`define DEGREE_ORDERED_GREEDY_GRAPH_COLORING_TOP_ASSERT_SVH

// Check that a condition holds at every edge
`define DOGC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("dogc check failed");

// Check that a condition holds in the cycle after a trigger
`define DOGC_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("dogc sequence check failed");

`endif

@@ src/dogc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogc_pkg
// Shared constants, codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package dogc_pkg;

   localparam int MAX_V = 64;
   localparam int VW    = 6;   // vertex index width
   localparam int CW    = 7;   // count and color width

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_EDGE_RD,
      OP_EDGE_WA,
      OP_EDGE_WB,
      OP_DEG_RD,
      OP_DEG_CNT,
      OP_PICK_RD,
      OP_PICK_SCAN,
      OP_PICK_DONE,
      OP_ROWS_LOAD,
      OP_INNER_TEST,
      OP_FREE_RD,
      OP_FREE_ROW,
      OP_FREE_SCAN,
      OP_FREE_FIND,
      OP_OUT_RD,
      OP_OUT_LOAD,
      OP_OUT_SEND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       edge_ok;
      logic       n_zero;
      logic       i_last;
      logic       j_last;
      logic       chunk_last;
      logic       found;
      logic       inner_hit;
      logic       free_done;
      logic       out_last;
   } status_type;

endpackage

@@ src/dogc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogc_req_if / dogc_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface dogc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [5:0] vertex_a;
   logic [5:0] vertex_b;
   modport source (output valid, action, vertex_a, vertex_b, input ready);
   modport sink (input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface dogc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] vertex_index;
   logic [5:0] vertex_color;
   logic [6:0] color_count;
   logic       last_vertex;
   modport source (output valid, vertex_index, vertex_color, color_count, last_vertex,
                   input ready);
   modport sink (input valid, vertex_index, vertex_color, color_count, last_vertex,
                 output ready);
endinterface

@@ src/dogc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogc_ram
// Simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dogc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and hold read data until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/dogc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogc_datapath
// Adjacency, degree and color stores with loop counters and scan logic.
// ----------------------------------------------------------------------------
module dogc_datapath
   import dogc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  logic [1:0]    req_action,
   input  logic [VW-1:0] req_a,
   input  logic [VW-1:0] req_b,
   input  logic          csr_we,
   input  logic [CW-1:0] csr_wdata,
   output logic [VW-1:0] out_index,
   output logic [VW-1:0] out_color,
   output logic [CW-1:0] out_count,
   output logic          out_last
);

   function automatic logic [3:0] popcount8(input logic [7:0] w);
      logic [3:0] c;
      c = '0;
      for (int k = 0; k < 8; k++) begin
         c = c + {3'b000, w[k]};
      end
      return c;
   endfunction

   // control registers
   logic [CW-1:0]    vc_ff, vc_in;
   logic [MAX_V-1:0] valid_ff, valid_in;
   logic [MAX_V-1:0] colored_ff, colored_in;
   logic             rowv_ff, rowv_in;
   // working registers
   logic [VW-1:0]    a_ff, a_in, b_ff, b_in;
   logic [VW-1:0]    i_ff, i_in, j_ff, j_in, s_ff, s_in;
   logic [2:0]       chunk_ff, chunk_in;
   logic [CW-1:0]    acc_ff, acc_in, best_ff, best_in, maxc_ff, maxc_in;
   logic             found_ff, found_in;
   logic [MAX_V-1:0] rows_ff, rows_in, rowj_ff, rowj_in, used_ff, used_in;
   logic [VW-1:0]    oidx_ff, oidx_in, ocol_ff, ocol_in;
   logic [CW-1:0]    ocnt_ff, ocnt_in;
   logic             olast_ff, olast_in;

   // memory ports
   logic             adj_we, adj_re;
   logic [VW-1:0]    adj_waddr, adj_raddr;
   logic [MAX_V-1:0] adj_wdata, adj_rdata;
   logic             deg_we, deg_re;
   logic [VW-1:0]    deg_waddr, deg_raddr;
   logic [CW-1:0]    deg_wdata, deg_rdata;
   logic             col_we, col_re;
   logic [VW-1:0]    col_waddr, col_raddr;
   logic [CW-1:0]    col_wdata, col_rdata;

   logic [CW-1:0]    n_eff;
   logic [VW-1:0]    n_last;
   logic [MAX_V-1:0] vmask, row_raw, row_q;
   logic [3:0]       pc;
   logic [7:0]       used_word;
   logic [2:0]       fz;
   logic             free_hit, free_done, inner_hit;
   logic [CW-1:0]    free_res;

   dogc_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj_ram (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_waddr), .wr_data(adj_wdata),
      .rd_en(adj_re), .rd_addr(adj_raddr), .rd_data(adj_rdata)
   );
   dogc_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_deg_ram (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
      .rd_en(deg_re), .rd_addr(deg_raddr), .rd_data(deg_rdata)
   );
   dogc_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_col_ram (
      .clock(clock), .wr_en(col_we), .wr_addr(col_waddr), .wr_data(col_wdata),
      .rd_en(col_re), .rd_addr(col_raddr), .rd_data(col_rdata)
   );

   // saturate vertex count and build the in-range mask
   always_comb begin
      n_eff  = (vc_ff > CW'(MAX_V)) ? CW'(MAX_V) : vc_ff;
      n_last = VW'(n_eff - CW'(1));
      for (int k = 0; k < MAX_V; k++) begin
         vmask[k] = (CW'(k) < n_eff);
      end
   end

   // unwritten rows read as empty
   assign row_raw = adj_rdata & {MAX_V{rowv_ff}};
   assign row_q   = row_raw & vmask;

   assign pc        = popcount8(row_q[{chunk_ff, 3'b000} +: 8]);
   assign inner_hit = !rows_ff[j_ff] && !colored_ff[j_ff];

   // first free color inside the current chunk of the used map
   always_comb begin
      used_word = used_ff[{chunk_ff, 3'b000} +: 8];
      free_hit  = (used_word != 8'hFF);
      fz        = '0;
      for (int k = 7; k >= 0; k--) begin
         if (!used_word[k]) begin
            fz = 3'(k);
         end
      end
      free_res  = free_hit ? {1'b0, chunk_ff, fz} : CW'(MAX_V);
      free_done = free_hit || (chunk_ff == 3'd7);
   end

   // datapath actions per command
   always_comb begin
      vc_in      = csr_we ? csr_wdata : vc_ff;
      valid_in   = valid_ff;
      colored_in = colored_ff;
      rowv_in    = rowv_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      s_in       = s_ff;
      chunk_in   = chunk_ff;
      acc_in     = acc_ff;
      best_in    = best_ff;
      maxc_in    = maxc_ff;
      found_in   = found_ff;
      rows_in    = rows_ff;
      rowj_in    = rowj_ff;
      used_in    = used_ff;
      oidx_in    = oidx_ff;
      ocol_in    = ocol_ff;
      ocnt_in    = ocnt_ff;
      olast_in   = olast_ff;
      adj_we     = 1'b0;
      adj_waddr  = '0;
      adj_wdata  = '0;
      adj_re     = 1'b0;
      adj_raddr  = '0;
      deg_we     = 1'b0;
      deg_waddr  = '0;
      deg_wdata  = '0;
      deg_re     = 1'b0;
      deg_raddr  = '0;
      col_we     = 1'b0;
      col_waddr  = '0;
      col_wdata  = '0;
      col_re     = 1'b0;
      col_raddr  = '0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            a_in = req_a;
            b_in = req_b;
            if (req_action == ACT_CLEAR) begin
               valid_in = '0;
            end
            if (req_action == ACT_START) begin
               colored_in = '0;
               maxc_in    = '0;
               i_in       = '0;
            end
         end
         OP_EDGE_RD: begin
            adj_re    = 1'b1;
            adj_raddr = a_ff;
         end
         OP_EDGE_WA: begin
            adj_we         = 1'b1;
            adj_waddr      = a_ff;
            adj_wdata      = row_raw | (MAX_V'(1) << b_ff);
            valid_in[a_ff] = 1'b1;
            adj_re         = 1'b1;
            adj_raddr      = b_ff;
         end
         OP_EDGE_WB: begin
            adj_we         = 1'b1;
            adj_waddr      = b_ff;
            adj_wdata      = row_raw | (MAX_V'(1) << a_ff);
            valid_in[b_ff] = 1'b1;
         end
         OP_DEG_RD: begin
            adj_re    = 1'b1;
            adj_raddr = i_ff;
            chunk_in  = '0;
            acc_in    = '0;
         end
         OP_DEG_CNT: begin
            acc_in   = acc_ff + {3'b000, pc};
            chunk_in = chunk_ff + 3'd1;
            if (chunk_ff == 3'd7) begin
               deg_we    = 1'b1;
               deg_waddr = i_ff;
               deg_wdata = acc_ff + {3'b000, pc};
               i_in      = i_ff + VW'(1);
            end
         end
         OP_PICK_RD: begin
            deg_re    = 1'b1;
            deg_raddr = '0;
            i_in      = '0;
            found_in  = 1'b0;
         end
         OP_PICK_SCAN: begin
            // keep the first uncolored vertex of highest degree
            if (!colored_ff[i_ff] && (!found_ff || (deg_rdata > best_ff))) begin
               best_in  = deg_rdata;
               s_in     = i_ff;
               found_in = 1'b1;
            end
            deg_re    = 1'b1;
            deg_raddr = i_ff + VW'(1);
            i_in      = i_ff + VW'(1);
         end
         OP_PICK_DONE: begin
            i_in = '0;
            j_in = '0;
            if (found_ff) begin
               col_we           = 1'b1;
               col_waddr        = s_ff;
               col_wdata        = '0;
               colored_in[s_ff] = 1'b1;
               adj_re           = 1'b1;
               adj_raddr        = s_ff;
            end
         end
         OP_ROWS_LOAD: begin
            rows_in = row_q;
         end
         OP_INNER_TEST: begin
            if (!inner_hit) begin
               j_in = j_ff + VW'(1);
            end
         end
         OP_FREE_RD: begin
            adj_re    = 1'b1;
            adj_raddr = j_ff;
         end
         OP_FREE_ROW: begin
            rowj_in   = row_q;
            used_in   = '0;
            col_re    = 1'b1;
            col_raddr = '0;
            i_in      = '0;
            chunk_in  = '0;
         end
         OP_FREE_SCAN: begin
            // mark colors held by colored neighbors
            if (rowj_ff[i_ff] && colored_ff[i_ff] && (col_rdata < CW'(MAX_V))) begin
               used_in[col_rdata[VW-1:0]] = 1'b1;
            end
            col_re    = 1'b1;
            col_raddr = i_ff + VW'(1);
            i_in      = i_ff + VW'(1);
         end
         OP_FREE_FIND: begin
            if (free_done) begin
               col_we           = 1'b1;
               col_waddr        = j_ff;
               col_wdata        = free_res;
               colored_in[j_ff] = 1'b1;
               if (free_res > maxc_ff) begin
                  maxc_in = free_res;
               end
               j_in = j_ff + VW'(1);
            end else begin
               chunk_in = chunk_ff + 3'd1;
            end
         end
         OP_OUT_RD: begin
            col_re    = 1'b1;
            col_raddr = i_ff;
         end
         OP_OUT_LOAD: begin
            oidx_in  = i_ff;
            ocol_in  = col_rdata[VW-1:0];
            ocnt_in  = maxc_ff + CW'(1);
            olast_in = (i_ff == n_last);
         end
         OP_OUT_SEND: begin
            i_in = i_ff + VW'(1);
         end
         default: begin
         end
      endcase
      if (adj_re) begin
         rowv_in = valid_ff[adj_raddr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff      <= CW'(MAX_V);
         valid_ff   <= '0;
         colored_ff <= '0;
         rowv_ff    <= 1'b0;
      end else begin
         vc_ff      <= vc_in;
         valid_ff   <= valid_in;
         colored_ff <= colored_in;
         rowv_ff    <= rowv_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      s_ff     <= s_in;
      chunk_ff <= chunk_in;
      acc_ff   <= acc_in;
      best_ff  <= best_in;
      maxc_ff  <= maxc_in;
      found_ff <= found_in;
      rows_ff  <= rows_in;
      rowj_ff  <= rowj_in;
      used_ff  <= used_in;
      oidx_ff  <= oidx_in;
      ocol_ff  <= ocol_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
   end

   // report status
   always_comb begin
      status.act        = req_action;
      status.edge_ok    = (req_a != req_b) && ({1'b0, req_a} < n_eff)
                          && ({1'b0, req_b} < n_eff);
      status.n_zero     = (n_eff == '0);
      status.i_last     = (i_ff == n_last);
      status.j_last     = (j_ff == n_last);
      status.chunk_last = (chunk_ff == 3'd7);
      status.found      = found_ff;
      status.inner_hit  = inner_hit;
      status.free_done  = free_done;
      status.out_last   = olast_ff;
   end

   assign out_index = oidx_ff;
   assign out_color = ocol_ff;
   assign out_count = ocnt_ff;
   assign out_last  = olast_ff;

endmodule

@@ src/dogc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogc_ctrl
// Sequencer for edge loads, degree pass, greedy coloring and result output.
// ----------------------------------------------------------------------------
module dogc_ctrl
   import dogc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [17:0] {
      ST_IDLE       = 18'h00001,
      ST_EDGE_RD    = 18'h00002,
      ST_EDGE_WA    = 18'h00004,
      ST_EDGE_WB    = 18'h00008,
      ST_DEG_RD     = 18'h00010,
      ST_DEG_CNT    = 18'h00020,
      ST_PICK_RD    = 18'h00040,
      ST_PICK_SCAN  = 18'h00080,
      ST_PICK_DONE  = 18'h00100,
      ST_ROWS_LOAD  = 18'h00200,
      ST_INNER_TEST = 18'h00400,
      ST_FREE_RD    = 18'h00800,
      ST_FREE_ROW   = 18'h01000,
      ST_FREE_SCAN  = 18'h02000,
      ST_FREE_FIND  = 18'h04000,
      ST_OUT_RD     = 18'h08000,
      ST_OUT_LOAD   = 18'h10000,
      ST_OUT_WAIT   = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT_WAIT);

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (status.act == ACT_ADD && status.edge_ok) begin
                  state_in = ST_EDGE_RD;
               end else if (status.act == ACT_START && !status.n_zero) begin
                  state_in = ST_DEG_RD;
               end
            end
         end
         ST_EDGE_RD: begin
            cmd.op   = OP_EDGE_RD;
            state_in = ST_EDGE_WA;
         end
         ST_EDGE_WA: begin
            cmd.op   = OP_EDGE_WA;
            state_in = ST_EDGE_WB;
         end
         ST_EDGE_WB: begin
            cmd.op   = OP_EDGE_WB;
            state_in = ST_IDLE;
         end
         ST_DEG_RD: begin
            cmd.op   = OP_DEG_RD;
            state_in = ST_DEG_CNT;
         end
         ST_DEG_CNT: begin
            cmd.op = OP_DEG_CNT;
            if (status.chunk_last) begin
               state_in = status.i_last ? ST_PICK_RD : ST_DEG_RD;
            end
         end
         ST_PICK_RD: begin
            cmd.op   = OP_PICK_RD;
            state_in = ST_PICK_SCAN;
         end
         ST_PICK_SCAN: begin
            cmd.op = OP_PICK_SCAN;
            if (status.i_last) begin
               state_in = ST_PICK_DONE;
            end
         end
         ST_PICK_DONE: begin
            cmd.op   = OP_PICK_DONE;
            state_in = status.found ? ST_ROWS_LOAD : ST_OUT_RD;
         end
         ST_ROWS_LOAD: begin
            cmd.op   = OP_ROWS_LOAD;
            state_in = ST_INNER_TEST;
         end
         ST_INNER_TEST: begin
            cmd.op = OP_INNER_TEST;
            if (status.inner_hit) begin
               state_in = ST_FREE_RD;
            end else if (status.j_last) begin
               state_in = ST_PICK_RD;
            end
         end
         ST_FREE_RD: begin
            cmd.op   = OP_FREE_RD;
            state_in = ST_FREE_ROW;
         end
         ST_FREE_ROW: begin
            cmd.op   = OP_FREE_ROW;
            state_in = ST_FREE_SCAN;
         end
         ST_FREE_SCAN: begin
            cmd.op = OP_FREE_SCAN;
            if (status.i_last) begin
               state_in = ST_FREE_FIND;
            end
         end
         ST_FREE_FIND: begin
            cmd.op = OP_FREE_FIND;
            if (status.free_done) begin
               state_in = status.j_last ? ST_PICK_RD : ST_INNER_TEST;
            end
         end
         ST_OUT_RD: begin
            cmd.op   = OP_OUT_RD;
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            cmd.op   = OP_OUT_LOAD;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               cmd.op   = OP_OUT_SEND;
               state_in = status.out_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/degree_ordered_greedy_graph_coloring_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_ordered_greedy_graph_coloring_top
// Greedy graph coloring; each pass starts from the uncolored vertex of highest degree.
// ----------------------------------------------------------------------------
// Request words add an edge, clear the graph or start a coloring run; one
// request is handled at a time. A run over n vertices has a degree pass (one
// adjacency row read, then eight 8-bit count steps per vertex), then for each
// start vertex a degree scan and a neighbor walk, plus, for every vertex colored
// inside that walk, a row read, a scan of the color RAM and a chunked free-color
// search. It then returns one response word per vertex in index order, each
// held until it is taken. The adjacency, degree and color RAMs have a single
// read port each.
// ----------------------------------------------------------------------------
module degree_ordered_greedy_graph_coloring_top
   import dogc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   dogc_req_if.sink      req_port,
   dogc_rsp_if.source    rsp_port,
   input  logic          csr_write_en,
   input  logic [CW-1:0] csr_write_data
);

`include "degree_ordered_greedy_graph_coloring_top_assert.svh"

   cmd_type    cmd;
   status_type status;

   dogc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dogc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_action (req_port.action),
      .req_a      (req_port.vertex_a),
      .req_b      (req_port.vertex_b),
      .csr_we     (csr_write_en),
      .csr_wdata  (csr_write_data),
      .out_index  (rsp_port.vertex_index),
      .out_color  (rsp_port.vertex_color),
      .out_count  (rsp_port.color_count),
      .out_last   (rsp_port.last_vertex)
   );

   // requests are never taken while a response word is pending
   `DOGC_ASSERT_ALWAYS(a_no_overlap, !(req_port.ready && rsp_port.valid))
   // the final response word returns the block to accepting requests
   `DOGC_ASSERT_NEXT(a_last_idle, rsp_port.valid && rsp_port.ready && rsp_port.last_vertex,
      req_port.ready)
   // a non-final response word keeps the run going
   `DOGC_ASSERT_NEXT(a_mid_busy, rsp_port.valid && rsp_port.ready && !rsp_port.last_vertex,
      !req_port.ready)

endmodule
